/* hw/rtl/lgs_pkg.sv */
// Package for the life generation step block: grid sizes, command codes,
// sequencer states, rule counts and the row memory request type.
// Depends on nothing; every other file of the block but the checker uses it.
package lgs_pkg;

  // Grid limits. The field widths fix the largest grid at 64 by 64 cells.
  localparam int MaxSide = 64;
  localparam int RowW    = $clog2(MaxSide);
  localparam int SideW   = 7;

  // B3/S23 neighbour counts.
  localparam logic [3:0] BirthCount = 4'd3;
  localparam logic [3:0] KeepLow    = 4'd2;
  localparam logic [3:0] KeepHigh   = 4'd3;

  typedef enum logic [1:0] {
    CmdWrite   = 2'd0,
    CmdRead    = 2'd1,
    CmdAdvance = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StCellRd,
    StCellUse,
    StLoad0,
    StLoad1,
    StLoad2,
    StRow,
    StResp
  } state_e;

  typedef logic [MaxSide-1:0] row_t;

  // One write port and one read port of the row memory.
  typedef struct packed {
    logic            we;
    logic [RowW-1:0] waddr;
    row_t            wdata;
    logic [RowW-1:0] raddr;
  } mem_req_t;

endpackage

/* hw/rtl/life_generation_step.sv */
// Top level of the life generation step block: sequencer, grid side register,
// result register. Depends on lgs_pkg, lgs_row_mem and lgs_row_unit.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     command_i, col_index_i, row_index_i,
//                                                   cell_alive_i
//   out      output     out_valid_o / out_stall_i   read_alive_o, step_done_o
//   cfg      input      cfg_we_i                    cfg_wdata_i (grid_side)
//
// A write or read of a cell inside the side goes from acceptance through reading the row,
// modifying or picking the bit and handing over the result, before it is ready again.
// A cell outside the side and the unused command code go straight to the result.
// An advance (straight to the result when the side is below 3) makes three row loads,
// takes one row per cycle through the row unit and the memory write port, then the result.
// Reset clears the per-row valid bits at once, so there is no clearing pass.
// A stalled result stays in the output register; a new beat is still taken, and its
// result then holds the block busy until the stalled beat has left.
module life_generation_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  col_index_i,
  input  logic [5:0]  row_index_i,
  input  logic        cell_alive_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        read_alive_o,
  output logic        step_done_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  lgs_pkg::state_e                 state_q, state_d;
  logic [1:0]                      cmd_q;
  logic [lgs_pkg::RowW-1:0]        row_q;
  logic [lgs_pkg::RowW-1:0]        col_q;
  logic                            alive_q;
  logic [lgs_pkg::RowW-1:0]        r_q, r_d;
  lgs_pkg::row_t                   prev_q, prev_d;
  lgs_pkg::row_t                   cur_q, cur_d;
  logic                            res_alive_q, res_alive_d;
  logic                            res_step_q, res_step_d;
  logic                            out_valid_q;
  logic                            out_alive_q;
  logic                            out_step_q;
  logic                            out_load;
  logic [lgs_pkg::SideW-1:0]       grid_side_q;
  logic [lgs_pkg::SideW-1:0]       side;
  logic                            in_grid;
  logic                            accept;
  lgs_pkg::mem_req_t               mem_req;
  lgs_pkg::row_t                   row_data;
  lgs_pkg::row_t                   new_row;
  lgs_pkg::row_t                   cell_row;

  // Sides above the grid size act as the full grid.
  assign side = (grid_side_q > lgs_pkg::SideW'(lgs_pkg::MaxSide))
              ? lgs_pkg::SideW'(lgs_pkg::MaxSide) : grid_side_q;

  assign in_grid = ({1'b0, row_index_i} < side) && ({1'b0, col_index_i} < side);

  assign in_stall_o = (state_q != lgs_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  lgs_row_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (row_data)
  );

  // The shared row unit: old rows above and below come from the sliding
  // window registers and the row just read.
  lgs_row_unit u_row (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .next_i (row_data),
    .side_i (side),
    .row_o  (new_row)
  );

  // Read-modify-write of a single cell.
  always_comb begin
    cell_row        = row_data;
    cell_row[col_q] = alive_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgs_pkg::StIdle;
      grid_side_q <= lgs_pkg::SideW'(64);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        grid_side_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      row_q   <= row_index_i;
      col_q   <= col_index_i;
      alive_q <= cell_alive_i;
    end
    r_q         <= r_d;
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    res_alive_q <= res_alive_d;
    res_step_q  <= res_step_d;
    if (out_load) begin
      out_alive_q <= res_alive_q;
      out_step_q  <= res_step_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    r_d           = r_q;
    prev_d        = prev_q;
    cur_d         = cur_q;
    res_alive_d   = res_alive_q;
    res_step_d    = res_step_q;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = row_q;
    mem_req.wdata = cell_row;
    mem_req.raddr = row_q;

    unique case (state_q)
      lgs_pkg::StIdle: begin
        res_alive_d = 1'b0;
        res_step_d  = 1'b0;
        r_d         = lgs_pkg::RowW'(1);
        if (accept) begin
          priority if (command_i == lgs_pkg::CmdWrite || command_i == lgs_pkg::CmdRead) begin
            state_d = in_grid ? lgs_pkg::StCellRd : lgs_pkg::StResp;
          end else if (command_i == lgs_pkg::CmdAdvance) begin
            res_step_d = 1'b1;
            state_d    = (side < lgs_pkg::SideW'(3)) ? lgs_pkg::StResp : lgs_pkg::StLoad0;
          end else begin
            // The unused command code only gets an empty result.
            state_d = lgs_pkg::StResp;
          end
        end
      end
      lgs_pkg::StCellRd: begin
        state_d = lgs_pkg::StCellUse;
      end
      lgs_pkg::StCellUse: begin
        if (cmd_q == lgs_pkg::CmdWrite) begin
          mem_req.we = 1'b1;
        end else begin
          res_alive_d = row_data[col_q];
        end
        state_d = lgs_pkg::StResp;
      end
      lgs_pkg::StLoad0: begin
        mem_req.raddr = lgs_pkg::RowW'(0);
        state_d       = lgs_pkg::StLoad1;
      end
      lgs_pkg::StLoad1: begin
        prev_d        = row_data;
        mem_req.raddr = lgs_pkg::RowW'(1);
        state_d       = lgs_pkg::StLoad2;
      end
      lgs_pkg::StLoad2: begin
        cur_d         = row_data;
        mem_req.raddr = lgs_pkg::RowW'(2);
        state_d       = lgs_pkg::StRow;
      end
      lgs_pkg::StRow: begin
        // Row r_q + 1 is on the read port; row r_q is written back while
        // the read of row r_q + 2 is issued.
        mem_req.we    = 1'b1;
        mem_req.waddr = r_q;
        mem_req.wdata = new_row;
        mem_req.raddr = r_q + lgs_pkg::RowW'(2);
        prev_d        = cur_q;
        cur_d         = row_data;
        r_d           = r_q + lgs_pkg::RowW'(1);
        if ({1'b0, r_q} == side - lgs_pkg::SideW'(2)) begin
          state_d = lgs_pkg::StResp;
        end
      end
      lgs_pkg::StResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = lgs_pkg::StIdle;
        end
      end
      default: begin
        state_d = lgs_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign read_alive_o = out_alive_q;
  assign step_done_o  = out_step_q;

endmodule

/* hw/rtl/lgs_row_mem.sv */
// Row memory of the cell grid: one row per entry, one write and one read port.
// Depends on lgs_pkg. A row never written since reset reads as all dead.
module lgs_row_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lgs_pkg::mem_req_t req_i,
  output lgs_pkg::row_t     rdata_o
);

  lgs_pkg::row_t                 mem_q [lgs_pkg::MaxSide];
  lgs_pkg::row_t                 rdata_q;
  logic                          rvalid_q;
  logic [lgs_pkg::MaxSide-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  // Per-row valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* hw/rtl/lgs_row_unit.sv */
// Row evolution unit: applies B3/S23 to one row from its old row and the two
// old rows around it. Depends on lgs_pkg. Cells outside the interior pass through.
module lgs_row_unit (
  input  lgs_pkg::row_t                 prev_i,
  input  lgs_pkg::row_t                 cur_i,
  input  lgs_pkg::row_t                 next_i,
  input  logic [lgs_pkg::SideW-1:0]     side_i,
  output lgs_pkg::row_t                 row_o
);

  logic [lgs_pkg::MaxSide+1:0] p_pad;
  logic [lgs_pkg::MaxSide+1:0] c_pad;
  logic [lgs_pkg::MaxSide+1:0] n_pad;

  // A dead column on each side keeps the edge cells' windows in range.
  assign p_pad = {1'b0, prev_i, 1'b0};
  assign c_pad = {1'b0, cur_i, 1'b0};
  assign n_pad = {1'b0, next_i, 1'b0};

  for (genvar c = 0; c < lgs_pkg::MaxSide; c++) begin : g_cell
    logic [3:0] cnt;
    logic       interior;
    logic       live_next;

    assign cnt = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
               + 4'(c_pad[c])                  + 4'(c_pad[c+2])
               + 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2]);

    assign interior = (c != 0) &&
                      ((lgs_pkg::SideW+1)'(c + 1) < {1'b0, side_i});

    assign live_next = cur_i[c] ? ((cnt >= lgs_pkg::KeepLow) && (cnt <= lgs_pkg::KeepHigh))
                                : (cnt == lgs_pkg::BirthCount);

    assign row_o[c] = interior ? live_next : cur_i[c];
  end

endmodule

/* hw/rtl/lgs_checker.sv */
// Port-level checker for the life generation step block, bound to the top level.
// Depends on the top level's port names only.
module lgs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic read_alive_o,
  input logic step_done_o
);

  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result beat dropped");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_alive_o) && $stable(step_done_o))
    else $error("stalled result payload changed");

  // Every accepted beat keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready right after accepting a beat");

  // A new result beat only appears at the end of work on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without work in progress");

  // A result is either read data or an advance acknowledgement, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(read_alive_o && step_done_o))
    else $error("read data and advance done in one result beat");

endmodule

bind life_generation_step lgs_checker u_lgs_checker (.*);
